>>> design/bts_pkg.sv
// Shared constants, types and helpers of the barycentric texture shader.
`timescale 1ns / 1ps

package bts_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MODE_W    = 2;
  localparam int PIX_W     = 12;
  localparam int FACE_W    = 12;
  localparam int WT_W      = 17;
  localparam int IDX_W     = 18;
  localparam int COL_W     = 8;
  localparam int RGB_W     = 3 * COL_W;
  localparam int DIM_W     = 13;
  localparam int SRC_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int SUM8_W    = 11;

  localparam logic [WT_W-1:0] ONE_FX = WT_W'(1) << FRAC_BITS;

  localparam logic [MODE_W-1:0] MODE_TEXEL  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CORNER = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SHADE  = 2'd2;

  localparam logic [SRC_W-1:0] SRC_WHITE    = 2'd0;
  localparam logic [SRC_W-1:0] SRC_BLEND    = 2'd1;
  localparam logic [SRC_W-1:0] SRC_NEAREST  = 2'd2;
  localparam logic [SRC_W-1:0] SRC_BILINEAR = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 13'd512;
  localparam logic [DIM_W-1:0] DIM_MAX   = 13'd4096;

  // idx / 3 as (idx * DIV3_MUL) >> DIV3_SHIFT, exact for 18-bit idx
  localparam int          DIV3_SHIFT = 20;
  localparam logic [18:0] DIV3_MUL   = 19'd349526;

  typedef struct packed {
    logic [RGB_W-1:0] rgb;
    logic [WT_W-1:0]  tu;
    logic [WT_W-1:0]  tv;
  } corner_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [PIX_W-1:0]  px;
    logic [PIX_W-1:0]  py;
    logic [FACE_W-1:0] face;
    logic [WT_W-1:0]   bu;
    logic [WT_W-1:0]   bv;
    logic [IDX_W-1:0]  idx;
    logic [RGB_W-1:0]  rgb;
    logic [WT_W-1:0]   tu;
    logic [WT_W-1:0]   tv;
  } item_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    r = d;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (d > DIM_MAX) begin
      r = DIM_MAX;
    end
    return r;
  endfunction

  function automatic logic [WT_W-1:0] clamp_one(input logic [WT_W+2:0] s);
    return (s > (WT_W+3)'(ONE_FX)) ? ONE_FX : WT_W'(s);
  endfunction

  function automatic logic [COL_W-1:0] chan(input logic [RGB_W-1:0] t, input int k);
    return t[RGB_W-1-COL_W*k -: COL_W];
  endfunction

  function automatic logic [COL_W-1:0] sat8(input logic [SUM8_W-1:0] s);
    return (s > SUM8_W'(255)) ? 8'hFF : COL_W'(s);
  endfunction

endpackage

>>> design/bts_if.sv
// Request, result and configuration channels of the texture shader.
`timescale 1ns / 1ps

interface bts_item_if;
  import bts_pkg::*;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [PIX_W-1:0]    pixel_x;
  logic [PIX_W-1:0]    pixel_y;
  logic [FACE_W-1:0]   face_id;
  logic [WT_W-1:0]     bary_u;
  logic [WT_W-1:0]     bary_v;
  logic [IDX_W-1:0]    entry_index;
  logic [COL_W-1:0]    red_in;
  logic [COL_W-1:0]    green_in;
  logic [COL_W-1:0]    blue_in;
  logic [WT_W-1:0]     tex_coord_u;
  logic [WT_W-1:0]     tex_coord_v;
  modport source(output valid, mode, pixel_x, pixel_y, face_id, bary_u, bary_v,
                 entry_index, red_in, green_in, blue_in, tex_coord_u, tex_coord_v,
                 input ready);
  modport sink(input valid, mode, pixel_x, pixel_y, face_id, bary_u, bary_v,
               entry_index, red_in, green_in, blue_in, tex_coord_u, tex_coord_v,
               output ready);
endinterface

interface bts_result_if;
  import bts_pkg::*;
  logic              valid;
  logic              ready;
  logic [PIX_W-1:0]  out_x;
  logic [PIX_W-1:0]  out_y;
  logic [COL_W-1:0]  red;
  logic [COL_W-1:0]  green;
  logic [COL_W-1:0]  blue;
  modport source(output valid, out_x, out_y, red, green, blue, input ready);
  modport sink(input valid, out_x, out_y, red, green, blue, output ready);
endinterface

interface bts_cfg_if;
  import bts_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [DIM_W-1:0]      data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> design/bts_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
`timescale 1ns / 1ps

module bts_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read data holds while the pipeline is stalled
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/barycentric_texture_shader_top.sv
// Barycentric texture shader: corner/texel stores and an in-order shading pipeline.
`timescale 1ns / 1ps

// Usage:
//   item   : valid/ready request channel. mode 0 writes a texel, mode 1 writes a
//            face corner (entry_index = face*3+corner), mode 2 shades one pixel.
//            Mode 3 is dropped. Only shade requests produce a result.
//   result : valid/ready, one pixel (out_x, out_y, red, green, blue) per shade.
//   cfg    : register writes, always ready; write only while the block is idle.
// Throughput is one request per cycle while result is not stalled. A shade
// result is valid once its request has passed 11 pipeline stages and the output
// register, with the corner table read in stage 1 and four texel store copies
// read in stage 9 (one per 2x2 bilinear neighbour). Writes land in the same
// stage that reads their store, so requests take effect strictly in order.
// When result is stalled the whole pipeline holds and item.ready drops; the
// output register keeps its pixel until taken.
// Reset clears the pipeline and sets colour source white, texture 512x512.
// The stores are not cleared; no clearing pass runs after reset.
module barycentric_texture_shader_top #(
  parameter int TEXEL_DEPTH = 262144,
  parameter int MAX_FACES   = 4096
) (
  input  logic            clk,
  input  logic            rst,
  bts_item_if.sink        item,
  bts_result_if.source    result,
  bts_cfg_if.sink         cfg
);
  import bts_pkg::*;

  localparam int TAW        = $clog2(TEXEL_DEPTH);
  localparam int FAW        = $clog2(MAX_FACES);
  localparam int LIN_W      = 24;
  localparam int NSTG       = 11;
  localparam int FMUL_W     = 14;
  localparam int FPROD_W    = FACE_W + FMUL_W;
  localparam int FMOD_SHIFT = FACE_W + FAW;
  localparam logic [FMUL_W-1:0] FMOD_MUL = FMUL_W'(((longint'(1) << FMOD_SHIFT)
      + longint'(MAX_FACES) - 1) / longint'(MAX_FACES));
  localparam int TMUL_W     = 26;
  localparam int TPROD_W    = LIN_W + TMUL_W;
  localparam int TMOD_SHIFT = LIN_W + TAW;
  localparam logic [TMUL_W-1:0] TMOD_MUL = TMUL_W'(((longint'(1) << TMOD_SHIFT)
      + longint'(TEXEL_DEPTH) - 1) / longint'(TEXEL_DEPTH));
  localparam int IPROD_W    = IDX_W + 19;
  localparam logic [63:0] CORNER_LIMIT = 64'(3 * longint'(MAX_FACES));
  localparam logic [63:0] TEXEL_LIMIT  = 64'(TEXEL_DEPTH);
  localparam int CP_W  = WT_W + COL_W;
  localparam int CS_W  = CP_W + 2;
  localparam int TC_W  = 2 * WT_W;
  localparam int TS_W  = TC_W + 2;
  localparam int FX_W  = 29;
  localparam int AW_W  = 2 * WT_W - 1;
  localparam int TP_W  = AW_W + COL_W;
  localparam int TPS_W = TP_W + 2;

  // configuration
  logic [SRC_W-1:0] color_source;
  logic [DIM_W-1:0] texture_width;
  logic [DIM_W-1:0] texture_height;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_source   <= SRC_WHITE;
      texture_width  <= DIM_RESET;
      texture_height <= DIM_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_SOURCE: color_source   <= SRC_W'(cfg.data);
        CFG_WIDTH:  texture_width  <= cfg.data;
        CFG_HEIGHT: texture_height <= cfg.data;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic            adv;
  logic            o_valid;
  logic [NSTG:1]   v;
  item_t           ctl [1:NSTG];

  assign adv        = !o_valid || result.ready;
  assign item.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[NSTG-1:1], item.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl[1] <= '{mode: item.mode, px: item.pixel_x, py: item.pixel_y,
                  face: item.face_id, bu: item.bary_u, bv: item.bary_v,
                  idx: item.entry_index,
                  rgb: {item.red_in, item.green_in, item.blue_in},
                  tu: item.tex_coord_u, tv: item.tex_coord_v};
      for (int k = 2; k <= NSTG; k++) begin
        ctl[k] <= ctl[k-1];
      end
    end
  end

  // stage 1: face row and corner bank by reciprocal multiply
  logic [FPROD_W-1:0] fprod;
  logic [IPROD_W-1:0] iprod;
  logic [16:0]        cq;
  logic [IDX_W-1:0]   crem;
  logic [FACE_W-1:0]  fq;
  logic [FACE_W-1:0]  frow_full;
  logic               corner_we;

  always_ff @(posedge clk) begin
    if (adv) begin
      fprod <= FPROD_W'(item.face_id) * FPROD_W'(FMOD_MUL);
      iprod <= IPROD_W'(item.entry_index) * IPROD_W'(DIV3_MUL);
    end
  end

  assign cq        = 17'(iprod >> DIV3_SHIFT);
  assign crem      = ctl[1].idx - IDX_W'(cq) * IDX_W'(3);
  assign fq        = FACE_W'(fprod >> FMOD_SHIFT);
  assign frow_full = ctl[1].face - FACE_W'(32'(fq) * 32'(MAX_FACES));
  assign corner_we = adv && v[1] && (ctl[1].mode == MODE_CORNER)
                     && (64'(ctl[1].idx) < CORNER_LIMIT);

  corner_t crd [3];

  for (genvar k = 0; k < 3; k++) begin : g_corner
    logic [$bits(corner_t)-1:0] rd;
    bts_ram #(.WIDTH($bits(corner_t)), .DEPTH(MAX_FACES)) u_ram (
      .clk   (clk),
      .en    (adv),
      .we    (corner_we && (crem == IDX_W'(k))),
      .waddr (FAW'(cq)),
      .wdata ({ctl[1].rgb, ctl[1].tu, ctl[1].tv}),
      .raddr (FAW'(frow_full)),
      .rdata (rd)
    );
    assign crd[k] = corner_t'(rd);
  end

  // stage 2: weight products
  logic [WT_W:0]   uv_sum;
  logic [WT_W-1:0] wts [3];
  logic [CP_W-1:0] cp3 [3][3];
  logic [TC_W-1:0] up3 [3];
  logic [TC_W-1:0] vp3 [3];

  assign uv_sum = {1'b0, ctl[2].bu} + {1'b0, ctl[2].bv};
  assign wts[0] = (uv_sum >= {1'b0, ONE_FX}) ? '0 : WT_W'({1'b0, ONE_FX} - uv_sum);
  assign wts[1] = ctl[2].bu;
  assign wts[2] = ctl[2].bv;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        for (int c = 0; c < 3; c++) begin
          cp3[k][c] <= CP_W'(wts[k]) * CP_W'(chan(crd[k].rgb, c));
        end
        up3[k] <= TC_W'(wts[k]) * TC_W'(crd[k].tu);
        vp3[k] <= TC_W'(wts[k]) * TC_W'(crd[k].tv);
      end
    end
  end

  // stage 3: sums, colour blend and coordinate clamp
  logic [CS_W-1:0]  csum [3];
  logic [TS_W-1:0]  usum;
  logic [TS_W-1:0]  vsum;
  logic [RGB_W-1:0] bl [4:NSTG];
  logic [WT_W-1:0]  iu4;
  logic [WT_W-1:0]  iv4;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      csum[c] = CS_W'(cp3[0][c]) + CS_W'(cp3[1][c]) + CS_W'(cp3[2][c]);
    end
    usum = TS_W'(up3[0]) + TS_W'(up3[1]) + TS_W'(up3[2]);
    vsum = TS_W'(vp3[0]) + TS_W'(vp3[1]) + TS_W'(vp3[2]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        bl[4][RGB_W-1-COL_W*c -: COL_W] <= sat8(SUM8_W'(csum[c] >> FRAC_BITS));
      end
      for (int k = 5; k <= NSTG; k++) begin
        bl[k] <= bl[k-1];
      end
      iu4 <= clamp_one((WT_W+3)'(usum >> FRAC_BITS));
      iv4 <= clamp_one((WT_W+3)'(vsum >> FRAC_BITS));
    end
  end

  // stage 4: scale to texel space, row flipped
  logic [DIM_W-1:0] wdim;
  logic [DIM_W-1:0] hdim;
  logic [PIX_W-1:0] wm1;
  logic [PIX_W-1:0] hm1;
  logic [FX_W-1:0]  fx5;
  logic [FX_W-1:0]  fy5;

  assign wdim = clamp_dim(texture_width);
  assign hdim = clamp_dim(texture_height);
  assign wm1  = PIX_W'(wdim - DIM_W'(1));
  assign hm1  = PIX_W'(hdim - DIM_W'(1));

  always_ff @(posedge clk) begin
    if (adv) begin
      fx5 <= FX_W'(iu4) * FX_W'(wm1);
      fy5 <= FX_W'(ONE_FX - iv4) * FX_W'(hm1);
    end
  end

  // stage 5: texel positions and row offsets
  logic                 near;
  logic [PIX_W-1:0]     xn, yn, x0, y0, x1, y1, xa, ya, yb;
  logic [FRAC_BITS-1:0] lx, ly;
  logic [PIX_W-1:0]     xa6, xb6;
  logic [LIN_W-1:0]     yaw6, ybw6;
  logic [FRAC_BITS-1:0] lx6, ly6;

  assign near = (color_source == SRC_NEAREST);
  assign xn   = PIX_W'((fx5 + FX_W'(ONE_FX >> 1)) >> FRAC_BITS);
  assign yn   = PIX_W'((fy5 + FX_W'(ONE_FX >> 1)) >> FRAC_BITS);
  assign x0   = PIX_W'(fx5 >> FRAC_BITS);
  assign y0   = PIX_W'(fy5 >> FRAC_BITS);
  assign lx   = fx5[FRAC_BITS-1:0];
  assign ly   = fy5[FRAC_BITS-1:0];
  assign x1   = (x0 >= wm1) ? wm1 : x0 + PIX_W'(1);
  assign y1   = (y0 >= hm1) ? hm1 : y0 + PIX_W'(1);
  assign xa   = near ? xn : x0;
  assign ya   = near ? yn : y0;
  assign yb   = y1;

  always_ff @(posedge clk) begin
    if (adv) begin
      xa6  <= xa;
      xb6  <= x1;
      yaw6 <= LIN_W'((LIN_W+1)'(ya) * (LIN_W+1)'(wdim));
      ybw6 <= LIN_W'((LIN_W+1)'(yb) * (LIN_W+1)'(wdim));
      lx6  <= lx;
      ly6  <= ly;
    end
  end

  // stage 6: linear addresses and bilinear weights (order 00, 10, 01, 11)
  logic [WT_W-1:0]  nlx, nly;
  logic [LIN_W-1:0] lin7 [4];
  logic [AW_W-1:0]  wt7 [4];

  assign nlx = ONE_FX - WT_W'(lx6);
  assign nly = ONE_FX - WT_W'(ly6);

  always_ff @(posedge clk) begin
    if (adv) begin
      lin7[0] <= yaw6 + LIN_W'(xa6);
      lin7[1] <= yaw6 + LIN_W'(xb6);
      lin7[2] <= ybw6 + LIN_W'(xa6);
      lin7[3] <= ybw6 + LIN_W'(xb6);
      wt7[0]  <= AW_W'(nlx) * AW_W'(nly);
      wt7[1]  <= AW_W'(lx6) * AW_W'(nly);
      wt7[2]  <= AW_W'(nlx) * AW_W'(ly6);
      wt7[3]  <= AW_W'(lx6) * AW_W'(ly6);
    end
  end

  // stages 7 and 8: address modulo store depth
  logic [TPROD_W-1:0] tprod8 [4];
  logic [LIN_W-1:0]   lin8 [4];
  logic [LIN_W-1:0]   lin9 [4];
  logic [LIN_W-1:0]   qm9 [4];
  logic [AW_W-1:0]    wt8 [4];
  logic [AW_W-1:0]    wt9 [4];
  logic [AW_W-1:0]    wt10 [4];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 4; j++) begin
        tprod8[j] <= TPROD_W'(lin7[j]) * TPROD_W'(TMOD_MUL);
        lin8[j]   <= lin7[j];
        wt8[j]    <= wt7[j];
        qm9[j]    <= LIN_W'(64'(tprod8[j] >> TMOD_SHIFT) * 64'(TEXEL_DEPTH));
        lin9[j]   <= lin8[j];
        wt9[j]    <= wt8[j];
        wt10[j]   <= wt9[j];
      end
    end
  end

  // stage 9: texel store, one copy per neighbour
  logic [TAW-1:0]   taddr [4];
  logic [RGB_W-1:0] trd [4];
  logic             tex_we;

  assign tex_we = adv && v[9] && (ctl[9].mode == MODE_TEXEL)
                  && (64'(ctl[9].idx) < TEXEL_LIMIT);

  for (genvar j = 0; j < 4; j++) begin : g_texel
    assign taddr[j] = TAW'(lin9[j] - qm9[j]);
    bts_ram #(.WIDTH(RGB_W), .DEPTH(TEXEL_DEPTH)) u_ram (
      .clk   (clk),
      .en    (adv),
      .we    (tex_we),
      .waddr (TAW'(ctl[9].idx)),
      .wdata (ctl[9].rgb),
      .raddr (taddr[j]),
      .rdata (trd[j])
    );
  end

  // stage 10: weighted texels
  logic [TP_W-1:0]  tp11 [4][3];
  logic [RGB_W-1:0] tn11;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 4; j++) begin
        for (int c = 0; c < 3; c++) begin
          tp11[j][c] <= TP_W'(wt10[j]) * TP_W'(chan(trd[j], c));
        end
      end
      tn11 <= trd[0];
    end
  end

  // stage 11: select source into the output register
  logic [TPS_W-1:0] tsum [3];
  logic [RGB_W-1:0] bil;
  logic [RGB_W-1:0] pick;
  logic [PIX_W-1:0] o_x, o_y;
  logic [RGB_W-1:0] o_rgb;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      tsum[c] = TPS_W'(tp11[0][c]) + TPS_W'(tp11[1][c])
              + TPS_W'(tp11[2][c]) + TPS_W'(tp11[3][c]);
      bil[RGB_W-1-COL_W*c -: COL_W] = sat8(SUM8_W'(tsum[c] >> (2 * FRAC_BITS)));
    end
    unique case (color_source)
      SRC_WHITE:    pick = '1;
      SRC_BLEND:    pick = bl[NSTG];
      SRC_NEAREST:  pick = tn11;
      SRC_BILINEAR: pick = bil;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv) begin
      o_valid <= v[NSTG] && (ctl[NSTG].mode == MODE_SHADE);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_x   <= ctl[NSTG].px;
      o_y   <= ctl[NSTG].py;
      o_rgb <= pick;
    end
  end

  assign result.valid = o_valid;
  assign result.out_x = o_x;
  assign result.out_y = o_y;
  assign result.red   = chan(o_rgb, 0);
  assign result.green = chan(o_rgb, 1);
  assign result.blue  = chan(o_rgb, 2);

`ifndef SYNTHESIS
  a_bank: assert property (@(posedge clk) disable iff (rst)
    v[1] && (ctl[1].mode == MODE_CORNER) |-> crem < IDX_W'(3))
    else $error("corner bank out of range");

  a_face: assert property (@(posedge clk) disable iff (rst)
    v[1] && (ctl[1].mode == MODE_SHADE) |-> 32'(frow_full) < 32'(MAX_FACES))
    else $error("face row out of range");

  a_weights: assert property (@(posedge clk) disable iff (rst)
    v[7] && (ctl[7].mode == MODE_SHADE) && (color_source == SRC_BILINEAR)
    |-> (35'(wt7[0]) + 35'(wt7[1]) + 35'(wt7[2]) + 35'(wt7[3])) == (35'(1) << 32))
    else $error("bilinear weights do not sum to one");

  a_addr: assert property (@(posedge clk) disable iff (rst)
    v[9] && (ctl[9].mode == MODE_SHADE)
    && ((color_source == SRC_NEAREST) || (color_source == SRC_BILINEAR))
    |-> 32'(lin9[0] - qm9[0]) < 32'(TEXEL_DEPTH))
    else $error("texel address beyond store");

  a_reset: assert property (@(posedge clk) rst |=> !o_valid)
    else $error("result valid after reset");
`endif

endmodule
